>>> rtl/ptxq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptxq_pkg
// Shared constants and types for the transmit packet queue: the queue geometry,
// the node layout and the result status codes.
// ----------------------------------------------------------------------------
package ptxq_pkg;

    // Queue geometry. QUEUE_DEPTH may range from 2 to 1024.
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

    // Node layout: four bytes, byte 0 in the low bits and sent first.
    localparam int NODE_BYTES = 4;
    localparam int BYTE_W     = 8;
    localparam int NODE_W     = NODE_BYTES * BYTE_W;
    localparam int BSEL_W     = $clog2(NODE_BYTES);

    localparam logic [BSEL_W-1:0] LAST_BYTE = BSEL_W'(NODE_BYTES - 1);

    // Input command codes.
    typedef enum logic
    {
        CMD_ENQUEUE  = 1'b0,
        CMD_TX_READY = 1'b1
    } cmd_t;

    // Result status codes.
    typedef enum logic [1:0]
    {
        ST_ACCEPTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_SENT     = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    // Step a ring index, wrapping from the last slot back to zero.
    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] slot);
        logic [IDX_W-1:0] result;
        if (slot == LAST_SLOT)
        begin
            result = '0;
        end
        else
        begin
            result = slot + IDX_W'(1);
        end
        return result;
    endfunction

endpackage

>>> rtl/packet_tx_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_tx_queue
// Circular queue of four-byte transmit nodes held in a RAM. An enqueue beat stores
// a node unless the queue is full; a transmit-ready beat reports an empty queue or
// pops the oldest node and sends its four bytes, first byte first, last byte marked.
// ----------------------------------------------------------------------------
// Enqueue: one beat per cycle while the output is free and no node is being sent;
//   its result beat is registered in the cycle after acceptance.
// Transmit ready: the RAM registers the head node on acceptance, S_READ latches it
//   into the node register, and S_SEND registers one byte per beat while the output
//   is free. An empty queue answers with a single registered result beat.
// Reset (rst_n low, asynchronous): queue empty, head and tail at zero, idle
//   flag set, no result pending. Node storage is not cleared.

module packet_tx_queue (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // first_byte, second_byte, third_byte, fourth_byte
    input  logic        s_tuser,   // cmd
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // tx_byte
    output logic        m_tlast,   // last
    output logic [2:0]  m_tuser    // status[1:0], idle
);

    typedef enum logic [2:0]
    {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_SEND = 3'b100
    } state_t;

    state_t                               state_reg, state_next;
    logic [ptxq_pkg::IDX_W-1:0]           head_reg, head_next;
    logic [ptxq_pkg::IDX_W-1:0]           tail_reg, tail_next;
    logic [ptxq_pkg::CNT_W-1:0]           count_reg, count_next;
    logic                                 idle_reg, idle_next;
    logic [ptxq_pkg::BSEL_W-1:0]          bsel_reg, bsel_next;
    logic [ptxq_pkg::NODE_W-1:0]          node_reg, node_next;

    logic                                 m_tvalid_reg, m_tvalid_next;
    logic [ptxq_pkg::BYTE_W-1:0]          m_tdata_reg, m_tdata_next;
    logic                                 m_tlast_reg, m_tlast_next;
    logic [2:0]                           m_tuser_reg, m_tuser_next;

    logic                                 out_free;
    logic                                 in_fire;
    logic                                 is_full;
    logic                                 is_empty;
    logic                                 ram_we;
    logic                                 ram_re;
    logic [ptxq_pkg::NODE_W-1:0]          ram_rdata;

    // Node storage.
    ptxq_ram #(
        .WIDTH (ptxq_pkg::NODE_W),
        .DEPTH (ptxq_pkg::QUEUE_DEPTH)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (s_tdata),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // Handshake qualifiers.
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign in_fire  = s_tvalid && s_tready;
    assign is_full  = (count_reg == ptxq_pkg::FULL_COUNT);
    assign is_empty = (count_reg == '0);

    // Queue control and result generation.
    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        idle_next     = idle_reg;
        bsel_next     = bsel_reg;
        node_next     = node_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tlast_next  = 1'b1;
                    if (ptxq_pkg::cmd_t'(s_tuser) == ptxq_pkg::CMD_ENQUEUE)
                    begin
                        if (is_full)
                        begin
                            m_tuser_next = {idle_reg, ptxq_pkg::ST_FULL};
                        end
                        else
                        begin
                            ram_we       = 1'b1;
                            tail_next    = ptxq_pkg::next_slot(tail_reg);
                            count_next   = count_reg + ptxq_pkg::CNT_W'(1);
                            m_tuser_next = {idle_reg, ptxq_pkg::ST_ACCEPTED};
                        end
                    end
                    else if (is_empty)
                    begin
                        idle_next    = 1'b1;
                        m_tuser_next = {1'b1, ptxq_pkg::ST_EMPTY};
                    end
                    else
                    begin
                        // Pop: read the head node, results follow byte by byte.
                        ram_re        = 1'b1;
                        idle_next     = 1'b0;
                        head_next     = ptxq_pkg::next_slot(head_reg);
                        count_next    = count_reg - ptxq_pkg::CNT_W'(1);
                        m_tvalid_next = m_tvalid_reg && !m_tready;
                        m_tdata_next  = m_tdata_reg;
                        m_tlast_next  = m_tlast_reg;
                        state_next    = S_READ;
                    end
                end
            end

            S_READ:
            begin
                node_next  = ram_rdata;
                bsel_next  = '0;
                state_next = S_SEND;
            end

            S_SEND:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = node_reg[bsel_reg * ptxq_pkg::BYTE_W +: ptxq_pkg::BYTE_W];
                    m_tlast_next  = (bsel_reg == ptxq_pkg::LAST_BYTE);
                    m_tuser_next  = {1'b0, ptxq_pkg::ST_SENT};
                    bsel_next     = bsel_reg + ptxq_pkg::BSEL_W'(1);
                    if (bsel_reg == ptxq_pkg::LAST_BYTE)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            idle_reg     <= 1'b1;
            bsel_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            idle_reg     <= idle_next;
            bsel_reg     <= bsel_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        node_reg    <= node_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // Checks on the queue bookkeeping.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ptxq_pkg::FULL_COUNT)
        else $error("entry count exceeds queue depth");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (is_empty || is_full) |-> (head_reg == tail_reg))
        else $error("head and tail disagree with entry count");

    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !is_full)
        else $error("node written into a full queue");

    a_no_read_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> !is_empty)
        else $error("node read from an empty queue");

    a_send_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEND) |-> !idle_reg)
        else $error("idle flag set while a node is being sent");

endmodule

>>> rtl/ptxq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptxq_ram
// Generic single-clock RAM with one write port and one read port. Read data
// is registered and appears in the cycle after the read enable.
// ----------------------------------------------------------------------------
module ptxq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
